@@ src/text_console_writer_macros.svh @@
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define TCW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/tcw_pkg.sv @@
`default_nettype none

package tcw_pkg;

    localparam logic [2:0] KIND_PUT_CUR   = 3'd0;
    localparam logic [2:0] KIND_PUT_POS   = 3'd1;
    localparam logic [2:0] KIND_BACKSPACE = 3'd2;
    localparam logic [2:0] KIND_CLEAR     = 3'd3;
    localparam logic [2:0] KIND_READ      = 3'd4;

    localparam logic [7:0] CODE_BLANK   = 8'h08;
    localparam logic [7:0] CODE_NEWLINE = 8'h0A;
    localparam logic [7:0] CODE_SPACE   = 8'h20;
    localparam logic [7:0] CODE_E       = 8'h45;
    localparam logic [7:0] ATTR_ERROR   = 8'h0C;
    localparam logic [7:0] ATTR_RESET   = 8'h0F;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] char_code;
        logic [7:0] attr;
        logic [6:0] col;
        logic [4:0] row;
    } item_t;

    typedef struct packed {
        logic [6:0] cursor_col;
        logic [4:0] cursor_row;
        logic [7:0] read_char;
        logic [7:0] read_attr;
        logic       pos_error;
    } result_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_READ_WAIT,
        ST_SCROLL_RD,
        ST_SCROLL_WR,
        ST_FILL_ZERO,
        ST_FILL_BLANK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic latch;
        logic exec;
        logic scroll_rd;
        logic scroll_wr;
        logic fill_wr;
        logic fill_blank;
        logic cnt_clr;
        logic cnt_tail;
        logic cnt_inc;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       scroll;
        logic       fill_last;
        logic       scroll_last;
    } status_t;

endpackage

`default_nettype wire

@@ src/tcw_ctrl.sv @@
`default_nettype none

module tcw_ctrl
    import tcw_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  status_t status,
    output logic    busy,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (status.fill_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (status.kind == KIND_CLEAR)
                begin
                    state_next = ST_FILL_BLANK;
                end
                else if (status.kind == KIND_READ)
                begin
                    state_next = ST_READ_WAIT;
                end
                else if (status.scroll)
                begin
                    state_next = ST_SCROLL_RD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_READ_WAIT:
            begin
                state_next = ST_DONE;
            end
            ST_SCROLL_RD:
            begin
                state_next = ST_SCROLL_WR;
            end
            ST_SCROLL_WR:
            begin
                state_next = status.scroll_last ? ST_FILL_ZERO : ST_SCROLL_RD;
            end
            ST_FILL_ZERO, ST_FILL_BLANK:
            begin
                if (status.fill_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = (state_reg != ST_IDLE);
        case (state_reg)
            ST_INIT:
            begin
                cmd.fill_wr = 1'b1;
                cmd.cnt_inc = 1'b1;
            end
            ST_IDLE:
            begin
                cmd.latch = start;
            end
            ST_EXEC:
            begin
                cmd.exec    = 1'b1;
                cmd.cnt_clr = 1'b1;
            end
            ST_SCROLL_RD:
            begin
                cmd.scroll_rd = 1'b1;
            end
            ST_SCROLL_WR:
            begin
                cmd.scroll_wr = 1'b1;
                // after the last row move, sweep the bottom row
                cmd.cnt_tail  = status.scroll_last;
                cmd.cnt_inc   = !status.scroll_last;
            end
            ST_FILL_ZERO:
            begin
                cmd.fill_wr = 1'b1;
                cmd.cnt_inc = 1'b1;
            end
            ST_FILL_BLANK:
            begin
                cmd.fill_wr    = 1'b1;
                cmd.fill_blank = 1'b1;
                cmd.cnt_inc    = 1'b1;
            end
            ST_DONE:
            begin
                cmd.emit = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ src/tcw_datapath.sv @@
`default_nettype none

module tcw_datapath
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  item_t      item,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  cmd_t       cmd,
    output status_t    status,
    output logic       done,
    output result_t    result
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);

    localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
    localparam logic [AW-1:0] TAIL_CELL  = AW'(CELLS - COLUMNS);
    localparam logic [AW-1:0] SCROLL_END = AW'(CELLS - COLUMNS - 1);
    localparam logic [AW-1:0] ROW_STEP   = AW'(COLUMNS);
    localparam logic [6:0]    COL_LIM    = 7'(COLUMNS);
    localparam logic [6:0]    LAST_COL   = 7'(COLUMNS - 1);
    localparam logic [5:0]    ROW_LIM    = 6'(ROWS);
    localparam logic [4:0]    LAST_ROW   = 5'(ROWS - 1);

    logic [15:0] mem [CELLS];

    item_t         item_reg;
    logic [7:0]    default_attr_reg;
    logic [6:0]    cur_col_reg;
    logic [4:0]    cur_row_reg;
    logic [AW-1:0] cnt_reg;
    logic [15:0]   rdata_reg;
    logic          err_reg;
    logic          hit_reg;
    result_t       result_reg;
    logic          done_reg;

    logic [7:0]    res_attr;
    logic          in_grid;
    logic          put_ok;
    logic [6:0]    put_col;
    logic [4:0]    put_row;
    logic [6:0]    bs_col;
    logic [4:0]    bs_row;
    logic [6:0]    tgt_col;
    logic [4:0]    tgt_row;
    logic [AW-1:0] tgt_addr;
    logic [6:0]    new_col;
    logic [5:0]    new_row_ext;
    logic          put_scroll;
    logic [4:0]    new_row;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;

    always_comb
    begin
        res_attr = (item_reg.attr == 8'd0) ? default_attr_reg : item_reg.attr;
        in_grid  = (item_reg.col < COL_LIM) && ({1'b0, item_reg.row} < ROW_LIM);
        put_ok   = (item_reg.kind == KIND_PUT_CUR)
                || ((item_reg.kind == KIND_PUT_POS) && in_grid);

        if (item_reg.kind == KIND_PUT_CUR)
        begin
            put_col = cur_col_reg;
            put_row = cur_row_reg;
        end
        else
        begin
            put_col = item_reg.col;
            put_row = item_reg.row;
        end

        // backspace stops at the top-left cell
        if (cur_col_reg != 7'd0)
        begin
            bs_col = cur_col_reg - 7'd1;
            bs_row = cur_row_reg;
        end
        else if (cur_row_reg != 5'd0)
        begin
            bs_col = LAST_COL;
            bs_row = cur_row_reg - 5'd1;
        end
        else
        begin
            bs_col = 7'd0;
            bs_row = 5'd0;
        end

        if (item_reg.kind == KIND_BACKSPACE)
        begin
            tgt_col = bs_col;
            tgt_row = bs_row;
        end
        else
        begin
            tgt_col = put_col;
            tgt_row = put_row;
        end
        tgt_addr = AW'(32'(tgt_row) * COLUMNS + 32'(tgt_col));

        if (item_reg.char_code == CODE_NEWLINE)
        begin
            new_col     = 7'd0;
            new_row_ext = {1'b0, put_row} + 6'd1;
        end
        else if (item_reg.char_code == CODE_BLANK)
        begin
            new_col     = put_col;
            new_row_ext = {1'b0, put_row};
        end
        else if (put_col == LAST_COL)
        begin
            new_col     = 7'd0;
            new_row_ext = {1'b0, put_row} + 6'd1;
        end
        else
        begin
            new_col     = put_col + 7'd1;
            new_row_ext = {1'b0, put_row};
        end
        put_scroll = (new_row_ext == ROW_LIM);
        new_row    = put_scroll ? LAST_ROW : new_row_ext[4:0];
    end

    assign status.kind        = item_reg.kind;
    assign status.scroll      = put_ok && put_scroll;
    assign status.fill_last   = (cnt_reg == LAST_CELL);
    assign status.scroll_last = (cnt_reg == SCROLL_END);

    // memory port selection
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cnt_reg;
        mem_wdata = 16'd0;
        mem_re    = 1'b0;
        mem_raddr = tgt_addr;
        if (cmd.exec)
        begin
            case (item_reg.kind)
                KIND_PUT_CUR, KIND_PUT_POS:
                begin
                    if (!in_grid && (item_reg.kind == KIND_PUT_POS))
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = LAST_CELL;
                        mem_wdata = {ATTR_ERROR, CODE_E};
                    end
                    else
                    begin
                        mem_we    = (item_reg.char_code != CODE_NEWLINE);
                        mem_waddr = tgt_addr;
                        mem_wdata = {res_attr, (item_reg.char_code == CODE_BLANK) ?
                                     CODE_SPACE : item_reg.char_code};
                    end
                end
                KIND_BACKSPACE:
                begin
                    mem_we    = 1'b1;
                    mem_waddr = tgt_addr;
                    mem_wdata = {default_attr_reg, CODE_SPACE};
                end
                KIND_READ:
                begin
                    mem_re = in_grid;
                end
                default:
                begin
                    mem_we = 1'b0;
                end
            endcase
        end
        else if (cmd.scroll_rd)
        begin
            mem_re    = 1'b1;
            mem_raddr = cnt_reg + ROW_STEP;
        end
        else if (cmd.scroll_wr)
        begin
            mem_we    = 1'b1;
            mem_wdata = rdata_reg;
        end
        else if (cmd.fill_wr)
        begin
            mem_we    = 1'b1;
            mem_wdata = cmd.fill_blank ? {default_attr_reg, CODE_SPACE} : 16'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            item_reg <= item;
        end
        if (cmd.exec)
        begin
            err_reg <= ((item_reg.kind == KIND_PUT_POS) || (item_reg.kind == KIND_READ))
                       && !in_grid;
            hit_reg <= (item_reg.kind == KIND_READ) && in_grid;
        end
        if (cmd.emit)
        begin
            result_reg.cursor_col <= cur_col_reg;
            result_reg.cursor_row <= cur_row_reg;
            result_reg.read_char  <= hit_reg ? rdata_reg[7:0] : 8'd0;
            result_reg.read_attr  <= hit_reg ? rdata_reg[15:8] : 8'd0;
            result_reg.pos_error  <= err_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_attr_reg <= ATTR_RESET;
            cur_col_reg      <= 7'd0;
            cur_row_reg      <= 5'd0;
            cnt_reg          <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                default_attr_reg <= cfg_wdata;
            end

            if (cmd.exec)
            begin
                if (put_ok)
                begin
                    cur_col_reg <= new_col;
                    cur_row_reg <= new_row;
                end
                else if (item_reg.kind == KIND_BACKSPACE)
                begin
                    cur_col_reg <= bs_col;
                    cur_row_reg <= bs_row;
                end
                else if (item_reg.kind == KIND_CLEAR)
                begin
                    cur_col_reg <= 7'd0;
                    cur_row_reg <= 5'd0;
                end
            end

            if (cmd.cnt_clr)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.cnt_tail)
            begin
                cnt_reg <= TAIL_CELL;
            end
            else if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + AW'(1);
            end

            done_reg <= cmd.emit;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

@@ src/text_console_writer.sv @@
// channel   direction  signals                 transfer
// --------  ---------  ----------------------  --------------------------------
// item      in         start, busy, item       taken when start and not busy
// result    out        done, result            held one cycle while done is high
// config    in         cfg_we, cfg_wdata       default attribute, written on cfg_we
//
// put, backspace and out-of-range put items step through EXEC and DONE; a read adds READ_WAIT
// a put that moves the cursor past the last row scrolls: SCROLL_RD and SCROLL_WR move one
// cell per state pair, then the bottom row is zeroed; clear fills every cell with blanks
// after reset the cell store is swept to zero with busy high
// done never waits on the receiver; a new item may start in the cycle done is shown
`default_nettype none

module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  item_t      item,
    output logic       done,
    output result_t    result,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata
);

    cmd_t    cmd;
    status_t status;

    tcw_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .done      (done),
        .result    (result)
    );

endmodule

`default_nettype wire

@@ src/tcw_checker.sv @@
`default_nettype none

`include "text_console_writer_macros.svh"

module tcw_checker
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    busy,
    input  logic    done,
    input  result_t result
);

    `TCW_ASSERT_NEXT(a_done_single, done, !done, "result strobe held for two cycles")
    `TCW_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy, "item taken but not busy")
    `TCW_ASSERT_NOW(a_cursor_in_grid, done, (result.cursor_col < 7'(COLUMNS)) && (result.cursor_row < 5'(ROWS)), "cursor outside grid")
    `TCW_ASSERT_NOW(a_error_no_data, done && result.pos_error, (result.read_char == 8'd0) && (result.read_attr == 8'd0), "read data on position error")

endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

`default_nettype wire
